/* sv/ctpq_pkg.sv */
// ----------------------------------------------------------------------------
// ctpq_pkg
// shared types and constants of the can transmit priority queue
// ----------------------------------------------------------------------------
package ctpq_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int ID_W = 29;
  localparam int LEN_W = 4;
  localparam int PAY_W = 64;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_FETCH   = 2'd1,
    ACT_REVERT  = 2'd2,
    ACT_CONFIRM = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_FULL    = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_INSERT,
    OP_REMOVE,
    OP_PUSH,
    OP_REMOVE_PUSH
  } list_op_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
  } cell_t;

  typedef struct packed {
    list_op_t          op;
    logic [ID_W-1:0]   key;
    logic [SLOT_W-1:0] mslot;
    logic [SLOT_W-1:0] new_slot;
    logic [ID_W-1:0]   new_id;
  } list_ctl_t;

endpackage

/* sv/ctpq_cell.sv */
// ----------------------------------------------------------------------------
// ctpq_cell
// one entry of an ordered slot list, shifts with its neighbors
// ----------------------------------------------------------------------------
module ctpq_cell (
  input  logic               clk,
  input  logic               rst,
  input  ctpq_pkg::list_ctl_t ctl,
  input  ctpq_pkg::cell_t    left,
  input  ctpq_pkg::cell_t    right,
  input  logic               gt_in,
  input  logic               match_in,
  output ctpq_pkg::cell_t    own,
  output logic               gt_out,
  output logic               match_out,
  output logic               eq,
  output logic               match
);
  import ctpq_pkg::*;

  cell_t own_next;
  logic  gt;

  assign gt = own.valid && (own.id > ctl.key);
  assign match = own.valid && (own.slot == ctl.mslot);
  assign eq = own.valid && (own.id == ctl.key);
  assign gt_out = gt_in | gt;
  assign match_out = match_in | match;

  always_comb begin
    own_next = own;
    case (ctl.op)
      OP_CLEAR: own_next.valid = 1'b0;
      OP_INSERT: begin
        if (gt_in) begin
          own_next = left;
        end else if (gt || (!own.valid && left.valid)) begin
          own_next = '{valid: 1'b1, slot: ctl.new_slot, id: ctl.new_id};
        end
      end
      OP_REMOVE: begin
        if (match_in || match) begin
          own_next = right;
        end
      end
      OP_PUSH: own_next = left;
      OP_REMOVE_PUSH: begin
        if (!match_in) begin
          own_next = left;
        end
      end
      default: own_next = own;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own.valid <= 1'b0;
    end else begin
      own.valid <= own_next.valid;
    end
    own.slot <= own_next.slot;
    own.id <= own_next.id;
  end

endmodule

/* sv/ctpq_list.sv */
// ----------------------------------------------------------------------------
// ctpq_list
// row of cells forming one ordered slot list
// ----------------------------------------------------------------------------
module ctpq_list (
  input  logic                               clk,
  input  logic                               rst,
  input  ctpq_pkg::list_ctl_t                ctl,
  output ctpq_pkg::cell_t                    head,
  output logic                               any_eq,
  output logic                               any_match,
  output logic [ctpq_pkg::ID_W-1:0]          match_id,
  output logic [ctpq_pkg::SLOT_COUNT-1:0]    valid_vec
);
  import ctpq_pkg::*;

  cell_t cells [SLOT_COUNT];
  cell_t lefts [SLOT_COUNT];
  cell_t rights [SLOT_COUNT];
  logic [SLOT_COUNT:0] gt_c;
  logic [SLOT_COUNT:0] m_c;
  logic [SLOT_COUNT-1:0] eqs;
  logic [SLOT_COUNT-1:0] hits;

  assign gt_c[0] = 1'b0;
  assign m_c[0] = 1'b0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{valid: 1'b1, slot: ctl.new_slot, id: ctl.new_id};
    end else begin : g_mid
      assign lefts[i] = cells[i-1];
    end
    if (i == SLOT_COUNT - 1) begin : g_last
      assign rights[i] = '0;
    end else begin : g_inner
      assign rights[i] = cells[i+1];
    end
    ctpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left      (lefts[i]),
      .right     (rights[i]),
      .gt_in     (gt_c[i]),
      .match_in  (m_c[i]),
      .own       (cells[i]),
      .gt_out    (gt_c[i+1]),
      .match_out (m_c[i+1]),
      .eq        (eqs[i]),
      .match     (hits[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  assign head = cells[0];
  assign any_eq = |eqs;
  assign any_match = m_c[SLOT_COUNT];

  always_comb begin
    match_id = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (hits[i]) begin
        match_id = match_id | cells[i].id;
      end
    end
  end

endmodule

/* sv/can_tx_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// can_tx_priority_queue_unit
// transmit frame cache with identifier priority or ring fifo ordering
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   action can_id data_length payload slot_handle
// out      output     out_valid/out_stall status slot_out id_out length_out payload_out
// cfg      input      cfg_valid/cfg_ready cfg_data (priority_mode)
//
// each transaction is captured into the input registers; once the output register
// is free, it updates the cell rows and frame store and loads the result register.
// a result waits in the output register while out_stall is high; one more
// transaction can be captured meanwhile, then in_stall stays high until the
// waiting result leaves. reset empties both lists and selects priority mode.
// ----------------------------------------------------------------------------
module can_tx_priority_queue_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [ctpq_pkg::ID_W-1:0]     can_id,
  input  logic [ctpq_pkg::LEN_W-1:0]    data_length,
  input  logic [ctpq_pkg::PAY_W-1:0]    payload,
  input  logic [ctpq_pkg::SLOT_W-1:0]   slot_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [ctpq_pkg::SLOT_W-1:0]   slot_out,
  output logic [ctpq_pkg::ID_W-1:0]     id_out,
  output logic [ctpq_pkg::LEN_W-1:0]    length_out,
  output logic [ctpq_pkg::PAY_W-1:0]    payload_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);
  import ctpq_pkg::*;

  state_t state, state_next;
  logic mode;
  logic mode_chg;

  action_t             r_action;
  logic [ID_W-1:0]     r_id;
  logic [LEN_W-1:0]    r_len;
  logic [PAY_W-1:0]    r_pay;
  logic [SLOT_W-1:0]   r_handle;

  logic [ID_W-1:0]     store_id  [SLOT_COUNT];
  logic [LEN_W-1:0]    store_len [SLOT_COUNT];
  logic [PAY_W-1:0]    store_pay [SLOT_COUNT];

  logic [CNT_W-1:0]    pending_count, pending_count_next;
  logic [CNT_W-1:0]    inflight_count, inflight_count_next;
  logic [SLOT_COUNT-1:0] free_mask, free_mask_next;
  logic [SLOT_W-1:0]   ring_write_index, ring_write_index_next;
  logic [SLOT_W-1:0]   ring_send_index, ring_send_index_next;
  logic [SLOT_W-1:0]   ring_confirm_index, ring_confirm_index_next;

  list_ctl_t p_ctl, i_ctl;
  cell_t     p_head, i_head;
  logic      p_eq, i_eq, p_match, i_match;
  logic [ID_W-1:0] p_match_id, i_match_id;
  logic [SLOT_COUNT-1:0] p_valid, i_valid;

  logic fire;
  logic out_free;
  status_t st;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] rd_slot;
  logic do_write;
  logic free_any;
  logic [SLOT_W-1:0] free_slot;

  assign cfg_ready = 1'b1;
  assign mode_chg = cfg_valid && cfg_ready && (cfg_data != mode);
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign fire = (state == S_EXEC) && out_free;

  ctpq_list u_pending (
    .clk(clk), .rst(rst), .ctl(p_ctl), .head(p_head), .any_eq(p_eq),
    .any_match(p_match), .match_id(p_match_id), .valid_vec(p_valid)
  );

  ctpq_list u_inflight (
    .clk(clk), .rst(rst), .ctl(i_ctl), .head(i_head), .any_eq(i_eq),
    .any_match(i_match), .match_id(i_match_id), .valid_vec(i_valid)
  );

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] i);
    return (i == SLOT_W'(SLOT_COUNT - 1)) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    free_any = 1'b0;
    free_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_any = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign rd_slot = mode ? p_head.slot : ring_send_index;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    p_ctl = '{op: OP_HOLD, key: r_id, mslot: r_handle, new_slot: free_slot, new_id: r_id};
    i_ctl = '{op: OP_HOLD, key: p_head.id, mslot: r_handle, new_slot: p_head.slot,
              new_id: p_head.id};
    pending_count_next = pending_count;
    inflight_count_next = inflight_count;
    free_mask_next = free_mask;
    ring_write_index_next = ring_write_index;
    ring_send_index_next = ring_send_index;
    ring_confirm_index_next = ring_confirm_index;
    st = ST_OK;
    slot = '0;
    do_write = 1'b0;
    case (r_action)
      ACT_ADD: begin
        if (r_len > MAX_LEN) begin
          st = ST_INVALID;
        end else if ((pending_count + inflight_count) >= CNT_W'(SLOT_COUNT)) begin
          st = ST_FULL;
        end else if (mode) begin
          if (!free_any) begin
            st = ST_FULL;
          end else begin
            slot = free_slot;
            do_write = 1'b1;
            p_ctl.op = OP_INSERT;
            pending_count_next = pending_count + 1'b1;
            free_mask_next[free_slot] = 1'b0;
          end
        end else begin
          slot = ring_write_index;
          do_write = 1'b1;
          ring_write_index_next = ring_next(ring_write_index);
          pending_count_next = pending_count + 1'b1;
        end
      end
      ACT_FETCH: begin
        if (pending_count == '0) begin
          st = ST_EMPTY;
        end else if (mode) begin
          if (i_eq) begin
            st = ST_BLOCKED;
          end else begin
            slot = p_head.slot;
            p_ctl.op = OP_REMOVE;
            p_ctl.mslot = p_head.slot;
            i_ctl.op = OP_INSERT;
            pending_count_next = pending_count - 1'b1;
            inflight_count_next = inflight_count + 1'b1;
          end
        end else begin
          slot = ring_send_index;
          ring_send_index_next = ring_next(ring_send_index);
          pending_count_next = pending_count - 1'b1;
          inflight_count_next = inflight_count + 1'b1;
        end
      end
      ACT_REVERT: begin
        if (mode) begin
          if (free_mask[r_handle]) begin
            st = ST_INVALID;
          end else begin
            slot = r_handle;
            p_ctl.new_slot = r_handle;
            i_ctl.mslot = r_handle;
            if (i_match) begin
              i_ctl.op = OP_REMOVE;
              p_ctl.op = OP_PUSH;
              p_ctl.new_id = i_match_id;
              inflight_count_next = inflight_count - 1'b1;
              pending_count_next = pending_count + 1'b1;
            end else begin
              p_ctl.op = OP_REMOVE_PUSH;
              p_ctl.new_id = p_match_id;
            end
          end
        end else begin
          if (inflight_count == '0) begin
            st = ST_INVALID;
          end else begin
            ring_send_index_next = (ring_send_index == '0) ?
                                   SLOT_W'(SLOT_COUNT - 1) : ring_send_index - 1'b1;
            slot = ring_send_index_next;
            inflight_count_next = inflight_count - 1'b1;
            pending_count_next = pending_count + 1'b1;
          end
        end
      end
      ACT_CONFIRM: begin
        if (inflight_count == '0) begin
          st = ST_EMPTY;
        end else if (mode) begin
          slot = i_head.slot;
          i_ctl.op = OP_REMOVE;
          i_ctl.mslot = i_head.slot;
          free_mask_next[i_head.slot] = 1'b1;
          inflight_count_next = inflight_count - 1'b1;
        end else begin
          slot = ring_confirm_index;
          ring_confirm_index_next = ring_next(ring_confirm_index);
          inflight_count_next = inflight_count - 1'b1;
        end
      end
      default: st = ST_INVALID;
    endcase
    if (mode_chg) begin
      p_ctl.op = OP_CLEAR;
      i_ctl.op = OP_CLEAR;
    end else if (!fire) begin
      p_ctl.op = OP_HOLD;
      i_ctl.op = OP_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= 1'b1;
      out_valid <= 1'b0;
      pending_count <= '0;
      inflight_count <= '0;
      free_mask <= '1;
      ring_write_index <= '0;
      ring_send_index <= '0;
      ring_confirm_index <= '0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (mode_chg) begin
        mode <= cfg_data;
        pending_count <= '0;
        inflight_count <= '0;
        free_mask <= '1;
        ring_write_index <= '0;
        ring_send_index <= '0;
        ring_confirm_index <= '0;
      end else if (fire) begin
        pending_count <= pending_count_next;
        inflight_count <= inflight_count_next;
        free_mask <= free_mask_next;
        ring_write_index <= ring_write_index_next;
        ring_send_index <= ring_send_index_next;
        ring_confirm_index <= ring_confirm_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      r_action <= action_t'(action);
      r_id <= can_id;
      r_len <= data_length;
      r_pay <= payload;
      r_handle <= slot_handle;
    end
    if (fire && do_write) begin
      store_id[slot] <= r_id;
      store_len[slot] <= r_len;
      store_pay[slot] <= r_pay;
    end
    if (fire) begin
      status <= st;
      slot_out <= slot;
      if (st == ST_OK && r_action == ACT_FETCH) begin
        id_out <= store_id[rd_slot];
        length_out <= store_len[rd_slot];
        payload_out <= store_pay[rd_slot];
      end else begin
        id_out <= '0;
        length_out <= '0;
        payload_out <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (pending_count + inflight_count) <= CNT_W'(SLOT_COUNT))
    else $error("slot count exceeded");

  a_free_mask: assert property (@(posedge clk) disable iff (rst)
    mode |-> ($countones(~free_mask) == int'(pending_count + inflight_count)))
    else $error("free mask out of step with counts");

  a_pend_cells: assert property (@(posedge clk) disable iff (rst)
    mode |-> ($countones(p_valid) == int'(pending_count)))
    else $error("pending cells out of step with count");

  a_infl_cells: assert property (@(posedge clk) disable iff (rst)
    mode |-> ($countones(i_valid) == int'(inflight_count)))
    else $error("in-flight cells out of step with count");

  a_pend_empty: assert property (@(posedge clk) disable iff (rst)
    (mode && pending_count == '0) |-> (!p_eq && !p_match))
    else $error("empty pending list reports a hit");

endmodule

/* tb/ctpq_checker.sv */
// ----------------------------------------------------------------------------
// ctpq_checker
// watches the transaction channels of the frame cache, predicts each result
// from its own copy of the slot lists and ring indices, and compares fields
// ----------------------------------------------------------------------------
module ctpq_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [ctpq_pkg::ID_W-1:0]   can_id,
  input  logic [ctpq_pkg::LEN_W-1:0]  data_length,
  input  logic [ctpq_pkg::PAY_W-1:0]  payload,
  input  logic [ctpq_pkg::SLOT_W-1:0] slot_handle,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [2:0]                  status,
  input  logic [ctpq_pkg::SLOT_W-1:0] slot_out,
  input  logic [ctpq_pkg::ID_W-1:0]   id_out,
  input  logic [ctpq_pkg::LEN_W-1:0]  length_out,
  input  logic [ctpq_pkg::PAY_W-1:0]  payload_out,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_data,
  output int                          errors,
  output int                          outstanding
);
  import ctpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t           st;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  pay;
  } frame_result_t;

  frame_result_t expected_frames[$];

  logic [ID_W-1:0]  slot_id [SLOT_COUNT];
  logic [LEN_W-1:0] slot_len[SLOT_COUNT];
  logic [PAY_W-1:0] slot_pay[SLOT_COUNT];
  int               pending_slots[$];
  int               inflight_slots[$];
  logic [SLOT_COUNT-1:0] free_slots;
  int               ring_pending, ring_inflight;
  int               wr_idx, send_idx, conf_idx;
  bit               by_priority;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  task automatic empty_cache();
    pending_slots.delete();
    inflight_slots.delete();
    free_slots = '1;
    ring_pending = 0;
    ring_inflight = 0;
    wr_idx = 0;
    send_idx = 0;
    conf_idx = 0;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic predict_action(input action_t act, input logic [ID_W-1:0] id,
                                input logic [LEN_W-1:0] len, input logic [PAY_W-1:0] pay,
                                input logic [SLOT_W-1:0] h, output frame_result_t r);
    int npend, ninfl, s, pos, at;
    bit blocked;
    r = '{ST_OK, '0, '0, '0, '0};
    npend = by_priority ? pending_slots.size() : ring_pending;
    ninfl = by_priority ? inflight_slots.size() : ring_inflight;
    case (act)
      ACT_ADD: begin
        if (len > MAX_LEN) begin
          r.st = ST_INVALID;
        end else if (npend + ninfl >= SLOT_COUNT) begin
          r.st = ST_FULL;
        end else begin
          if (by_priority) begin
            s = 0;
            while (!free_slots[s]) s++;
            free_slots[s] = 1'b0;
          end else begin
            s = wr_idx;
            wr_idx = (wr_idx + 1) % SLOT_COUNT;
            ring_pending++;
          end
          slot_id[s] = id;
          slot_len[s] = len;
          slot_pay[s] = pay;
          if (by_priority) begin
            pos = 0;
            while (pos < pending_slots.size() && slot_id[pending_slots[pos]] <= id) pos++;
            pending_slots.insert(pos, s);
          end
          r.slot = s;
        end
      end
      ACT_FETCH: begin
        if (npend == 0) begin
          r.st = ST_EMPTY;
        end else if (by_priority) begin
          s = pending_slots[0];
          blocked = 0;
          pos = 0;
          foreach (inflight_slots[i]) begin
            if (slot_id[inflight_slots[i]] == slot_id[s]) blocked = 1;
            if (slot_id[inflight_slots[i]] < slot_id[s]) pos = i + 1;
          end
          if (blocked) begin
            r.st = ST_BLOCKED;
          end else begin
            pending_slots.delete(0);
            inflight_slots.insert(pos, s);
            r.slot = s;
          end
        end else begin
          r.slot = send_idx;
          send_idx = (send_idx + 1) % SLOT_COUNT;
          ring_pending--;
          ring_inflight++;
        end
        if (r.st == ST_OK) begin
          r.id = slot_id[r.slot];
          r.len = slot_len[r.slot];
          r.pay = slot_pay[r.slot];
        end
      end
      ACT_REVERT: begin
        if (by_priority) begin
          if (free_slots[h]) begin
            r.st = ST_INVALID;
          end else begin
            at = -1;
            foreach (inflight_slots[i]) if (inflight_slots[i] == h) at = i;
            if (at >= 0) begin
              inflight_slots.delete(at);
            end else begin
              foreach (pending_slots[i]) if (pending_slots[i] == h) at = i;
              if (at >= 0) pending_slots.delete(at);
            end
            pending_slots.push_front(h);
            r.slot = h;
          end
        end else if (ring_inflight == 0) begin
          r.st = ST_INVALID;
        end else begin
          send_idx = (send_idx + SLOT_COUNT - 1) % SLOT_COUNT;
          ring_inflight--;
          ring_pending++;
          r.slot = send_idx;
        end
      end
      default: begin
        if (ninfl == 0) begin
          r.st = ST_EMPTY;
        end else if (by_priority) begin
          s = inflight_slots.pop_front();
          free_slots[s] = 1'b1;
          r.slot = s;
        end else begin
          r.slot = conf_idx;
          conf_idx = (conf_idx + 1) % SLOT_COUNT;
          ring_inflight--;
        end
      end
    endcase
    if (r.st != ST_OK) r.slot = '0;
  endtask

  always @(posedge clk) begin
    frame_result_t r, w;
    if (rst) begin
      by_priority = 1;
      empty_cache();
      expected_frames.delete();
    end else begin
      if (cfg_valid && cfg_ready && (cfg_data != by_priority)) begin
        by_priority = cfg_data;
        empty_cache();
      end
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          report("unexpected result, status", status, 0);
        end else begin
          w = expected_frames.pop_front();
          if (status !== w.st) report("status", status, w.st);
          if (slot_out !== w.slot) report("slot_out", slot_out, w.slot);
          if (id_out !== w.id) report("id_out", id_out, w.id);
          if (length_out !== w.len) report("length_out", length_out, w.len);
          if (payload_out !== w.pay) report("payload_out", payload_out, w.pay);
        end
      end
      if (in_valid && !in_stall) begin
        predict_action(action_t'(action), can_id, data_length, payload, slot_handle, r);
        expected_frames.push_back(r);
      end
    end
    outstanding = expected_frames.size();
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives add, fetch, revert and confirm transactions into the frame cache in
// both ordering modes with random gaps and output stalls; the checker scores
// ----------------------------------------------------------------------------
module tb_top;
  import ctpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        action;
  logic [ID_W-1:0]   can_id;
  logic [LEN_W-1:0]  data_length;
  logic [PAY_W-1:0]  payload;
  logic [SLOT_W-1:0] slot_handle;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        status;
  logic [SLOT_W-1:0] slot_out;
  logic [ID_W-1:0]   id_out;
  logic [LEN_W-1:0]  length_out;
  logic [PAY_W-1:0]  payload_out;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;
  int                errors;
  int                outstanding;
  int                sent;
  int                mode_writes;
  bit                hold_long;

  can_tx_priority_queue_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .can_id(can_id), .data_length(data_length),
    .payload(payload), .slot_handle(slot_handle),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .slot_out(slot_out), .id_out(id_out),
    .length_out(length_out), .payload_out(payload_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ctpq_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .can_id(can_id), .data_length(data_length),
    .payload(payload), .slot_handle(slot_handle),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .slot_out(slot_out), .id_out(id_out),
    .length_out(length_out), .payload_out(payload_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("timeout");
    $display("can_tx_priority_queue_unit: mismatch");
    $finish;
  end

  // receiver: random hold per result, one long hold on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      n = $urandom_range(0, 4);
      if (hold_long) begin
        n = 80;
        hold_long = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  task automatic send_frame(action_t act, logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                            logic [PAY_W-1:0] pay, logic [SLOT_W-1:0] h);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    can_id <= id;
    data_length <= len;
    payload <= pay;
    slot_handle <= h;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  task automatic random_frame();
    action_t act;
    logic [ID_W-1:0] id;
    logic [LEN_W-1:0] len;
    int pick;
    pick = $urandom_range(0, 99);
    act = pick < 40 ? ACT_ADD : pick < 65 ? ACT_FETCH : pick < 80 ? ACT_REVERT : ACT_CONFIRM;
    id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 5));
    len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                      : LEN_W'($urandom_range(0, 8));
    send_frame(act, id, len, {$urandom, $urandom}, SLOT_W'($urandom_range(0, 7)));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_ADD;
    can_id = '0;
    data_length = '0;
    payload = '0;
    slot_handle = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b1;
    sent = 0;
    mode_writes = 0;
    hold_long = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // priority mode corners
    send_frame(ACT_FETCH, '0, '0, '0, '0);
    send_frame(ACT_CONFIRM, '0, '0, '0, '0);
    send_frame(ACT_REVERT, '0, '0, '0, 3'd7);
    send_frame(ACT_ADD, '1, 4'd9, '1, '0);
    send_frame(ACT_ADD, '0, 4'd0, '0, '0);
    send_frame(ACT_ADD, '1, 4'd8, '1, '1);
    send_frame(ACT_ADD, 29'd5, 4'd3, 64'h0123_4567_89ab_cdef, '0);
    send_frame(ACT_ADD, 29'd5, 4'd15, 64'hfedc_ba98_7654_3210, '0);
    send_frame(ACT_ADD, 29'd5, 4'd4, 64'hfedc_ba98_7654_3210, '0);
    send_frame(ACT_FETCH, '0, '0, '0, '0);
    send_frame(ACT_FETCH, '0, '0, '0, '0);
    send_frame(ACT_FETCH, '0, '0, '0, '0);
    send_frame(ACT_REVERT, '0, '0, '0, 3'd2);
    send_frame(ACT_REVERT, '0, '0, '0, 3'd1);
    send_frame(ACT_CONFIRM, '0, '0, '0, '0);
    for (int i = 0; i < 6; i++) send_frame(ACT_ADD, ID_W'(i), 4'd1, '0, '0);

    // ring mode corners
    write_mode(1'b0);
    write_mode(1'b0);
    send_frame(ACT_FETCH, '0, '0, '0, '0);
    send_frame(ACT_REVERT, '0, '0, '0, 3'd5);
    send_frame(ACT_CONFIRM, '0, '0, '0, '0);
    for (int i = 0; i < 9; i++) send_frame(ACT_ADD, '1, 4'd8, {$urandom, $urandom}, '0);
    send_frame(ACT_FETCH, '0, '0, '0, '0);
    send_frame(ACT_REVERT, '0, '0, '0, '0);
    send_frame(ACT_FETCH, '0, '0, '0, '0);
    send_frame(ACT_CONFIRM, '0, '0, '0, '0);

    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph % 2 == 0);
      for (int k = 0; k < 300; k++) begin
        if (ph == 1 && k == 150) hold_long = 1;
        if (ph == 2 && k == 150) drain();
        random_frame();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d transactions in both ordering modes, %0d mode writes", sent, mode_writes);
    $display("long output hold and full drain pause included");
    if (errors == 0) begin
      $display("can_tx_priority_queue_unit: match");
    end else begin
      $display("can_tx_priority_queue_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/ctpq_pkg.sv
sv/ctpq_cell.sv
sv/ctpq_list.sv
sv/can_tx_priority_queue_unit.sv
tb/ctpq_checker.sv
tb/tb_top.sv
